/* hw/rtl/ihash_pkg.sv */
// shared codes, widths, defaults and hash mixing steps for the integer key hash table
package ihash_pkg;

	localparam int unsigned DEF_NUM_BUCKETS = 256;
	localparam int unsigned DEF_WAYS        = 4;

	localparam int unsigned KEY_W    = 32;
	localparam int unsigned VAL_W    = 32;
	localparam int unsigned ACT_W    = 2;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned ECNT_W   = 11;
	localparam int unsigned IN_DATA_W  = 64;
	localparam int unsigned OUT_DATA_W = 48;

	// action codes
	localparam logic [ACT_W-1:0] ACT_PUT    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_GET    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_MISSING = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL    = 2'd2;

	// first half of the integer mix
	function automatic logic [KEY_W-1:0] mix_head(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] t;
		t = k + ~(k << 15);
		t = t ^ (t >> 10);
		t = t + (t << 3);
		return t;
	endfunction

	// second half of the integer mix
	function automatic logic [KEY_W-1:0] mix_tail(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] t;
		t = k ^ (k >> 6);
		t = t + ~(t << 11);
		t = t ^ (t >> 16);
		return t;
	endfunction

endpackage

/* hw/rtl/integer_key_hash_table_top.sv */
// integer key hash table: bucketed key/value store held in two row memories
//
//  channel | dir | tdata (low bit up)              | tuser
//  s_*     | in  | lookup_key, entry_value         | action
//  m_*     | out | read_value, entry_count, zeros  | status
//
// one word at a time: accept, mix and finish states, row read, lookup and write-back;
// when NUM_BUCKETS is not a power of two above one, a remainder state reduces the
// finished hash modulo NUM_BUCKETS before the row read, 4 hash bits a cycle.
// after reset a clearing pass writes every key row, with s_tready low.
// a finished word waits in the output register; the next word is taken meanwhile,
// and the lookup stage holds its write-back until the output register is free.
module integer_key_hash_table_top #(
	parameter int unsigned NUM_BUCKETS = ihash_pkg::DEF_NUM_BUCKETS,
	parameter int unsigned WAYS        = ihash_pkg::DEF_WAYS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ihash_pkg::IN_DATA_W-1:0]   s_tdata,   // lookup_key, entry_value
	input  logic [ihash_pkg::ACT_W-1:0]       s_tuser,   // action
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ihash_pkg::OUT_DATA_W-1:0]  m_tdata,   // read_value, entry_count, zero pad
	output logic [ihash_pkg::STAT_W-1:0]      m_tuser    // status
);
	import ihash_pkg::*;

	localparam int unsigned ADDR_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int unsigned REM_W  = ADDR_W + 1;
	localparam int unsigned WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int unsigned CNT_W  = $clog2(NUM_BUCKETS * WAYS + 1);
	localparam bit          IS_POW2 = (NUM_BUCKETS > 1) &&
		((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
	localparam logic [REM_W-1:0]  NB_R     = REM_W'(NUM_BUCKETS);
	localparam logic [ADDR_W-1:0] LAST_ROW = ADDR_W'(NUM_BUCKETS - 1);
	localparam int unsigned MOD_STEPS = 8;   // 32 hash bits, 4 per cycle

	typedef struct packed {
		logic [WAYS-1:0][KEY_W-1:0] key;
		logic [WAYS-1:0]            vld;
	} krow_t;

	typedef logic [WAYS-1:0][VAL_W-1:0] vrow_t;

	typedef enum logic [6:0] {
		ST_CLR  = 7'b0000001,
		ST_IDLE = 7'b0000010,
		ST_MIX  = 7'b0000100,
		ST_FIN  = 7'b0001000,
		ST_MOD  = 7'b0010000,
		ST_RD   = 7'b0100000,
		ST_LOOK = 7'b1000000
	} state_t;

	// control
	state_t             state_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [2:0]         mod_cnt_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               m_tvalid_q;

	// payload
	logic [ACT_W-1:0]   act_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   val_q;
	logic [KEY_W-1:0]   hsh_q;
	logic [REM_W-1:0]   rem_q;
	logic [ADDR_W-1:0]  bkt_q;
	logic [STAT_W-1:0]  stat_q;
	logic [VAL_W-1:0]   rdv_q;
	logic [ECNT_W-1:0]  ecnt_q;

	// bucket row memories
	krow_t key_mem [NUM_BUCKETS];
	vrow_t val_mem [NUM_BUCKETS];
	krow_t krow_q;
	vrow_t vrow_q;

	logic               in_acc;
	logic               out_free;
	logic               look_go;
	logic [KEY_W-1:0]   mix_t;
	logic [REM_W-1:0]   rem_t;
	logic               hit;
	logic               has_free;
	logic [WAY_W-1:0]   hit_idx;
	logic [WAY_W-1:0]   free_idx;
	logic [STAT_W-1:0]  stat_d;
	logic [VAL_W-1:0]   rdv_d;
	logic [CNT_W-1:0]   cnt_d;
	logic               kwr_en;
	logic [ADDR_W-1:0]  kwr_addr;
	krow_t              kwr_data;
	logic               vwr_en;
	vrow_t              vwr_data;
	logic [31:0]        cnt_ext;

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign look_go  = (state_q == ST_LOOK) && out_free;

	// second half of the mix, finished hash
	assign mix_t = mix_tail(hsh_q);

	// four remainder digits a cycle, msb first
	always_comb begin
		rem_t = rem_q;
		for (int i = 0; i < 4; i++) begin
			rem_t = {rem_t[REM_W-2:0], hsh_q[KEY_W-1-i]};
			if (rem_t >= NB_R) begin
				rem_t = rem_t - NB_R;
			end
		end
	end

	// way match and first free way, lowest way wins
	always_comb begin
		hit      = 1'b0;
		has_free = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (krow_q.vld[w]) begin
				if (krow_q.key[w] == key_q) begin
					hit     = 1'b1;
					hit_idx = WAY_W'(w);
				end
			end else begin
				has_free = 1'b1;
				free_idx = WAY_W'(w);
			end
		end
	end

	// operation result and write-back rows
	always_comb begin
		stat_d   = STAT_OK;
		rdv_d    = '0;
		cnt_d    = cnt_q;
		kwr_data = krow_q;
		vwr_data = vrow_q;
		kwr_en   = 1'b0;
		vwr_en   = 1'b0;
		case (act_q)
			ACT_PUT: begin
				if (hit) begin
					vwr_data[hit_idx] = val_q;
					vwr_en = look_go;
				end else if (has_free) begin
					kwr_data.vld[free_idx] = 1'b1;
					kwr_data.key[free_idx] = key_q;
					vwr_data[free_idx]     = val_q;
					kwr_en = look_go;
					vwr_en = look_go;
					cnt_d  = cnt_q + CNT_W'(1);
				end else begin
					stat_d = STAT_FULL;
				end
			end
			ACT_GET: begin
				if (hit) begin
					rdv_d = vrow_q[hit_idx];
				end else begin
					stat_d = STAT_MISSING;
				end
			end
			ACT_REMOVE: begin
				if (hit) begin
					kwr_data.vld[hit_idx] = 1'b0;
					kwr_en = look_go;
					if (cnt_q != '0) begin
						cnt_d = cnt_q - CNT_W'(1);
					end
				end else begin
					stat_d = STAT_MISSING;
				end
			end
			default: begin
				stat_d = STAT_OK;
			end
		endcase
		// clearing pass owns the key write port
		if (state_q == ST_CLR) begin
			kwr_en   = 1'b1;
			kwr_data = '0;
		end
	end

	assign kwr_addr = (state_q == ST_CLR) ? clr_q : bkt_q;
	assign cnt_ext  = 32'(cnt_d);

	// memories: one row read, one row write
	always_ff @(posedge clk) begin
		if (state_q == ST_RD) begin
			krow_q <= key_mem[bkt_q];
			vrow_q <= val_mem[bkt_q];
		end
		if (kwr_en) begin
			key_mem[kwr_addr] <= kwr_data;
		end
		if (vwr_en) begin
			val_mem[bkt_q] <= vwr_data;
		end
	end

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			clr_q      <= '0;
			mod_cnt_q  <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// output register: loaded by the lookup, emptied by the sink
			if (look_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == LAST_ROW) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_MIX;
					end
				end
				ST_MIX: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					mod_cnt_q <= '0;
					state_q   <= IS_POW2 ? ST_RD : ST_MOD;
				end
				ST_MOD: begin
					mod_cnt_q <= mod_cnt_q + 3'd1;
					if (mod_cnt_q == 3'(MOD_STEPS - 1)) begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_LOOK;
				end
				ST_LOOK: begin
					if (out_free) begin
						cnt_q   <= cnt_d;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			act_q <= s_tuser;
			key_q <= s_tdata[KEY_W-1:0];
			val_q <= s_tdata[KEY_W+VAL_W-1:KEY_W];
		end
		if (state_q == ST_MIX) begin
			hsh_q <= mix_head(key_q);
		end
		if (state_q == ST_FIN) begin
			hsh_q <= mix_t;
			rem_q <= '0;
			bkt_q <= mix_t[ADDR_W-1:0];
		end
		if (state_q == ST_MOD) begin
			hsh_q <= hsh_q << 4;
			rem_q <= rem_t;
			bkt_q <= rem_t[ADDR_W-1:0];
		end
		if (look_go) begin
			stat_q <= stat_d;
			rdv_q  <= rdv_d;
			ecnt_q <= cnt_ext[ECNT_W-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = stat_q;
	assign m_tdata  = {{(OUT_DATA_W - VAL_W - ECNT_W){1'b0}}, ecnt_q, rdv_q};

`ifndef SYNTHESIS
	// a new word appears only out of the lookup stage
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_LOOK))
		else $error("result word without lookup");

	// entry count moves by at most one per word
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |->
		((cnt_q == $past(cnt_q) + CNT_W'(1)) || (cnt_q == $past(cnt_q) - CNT_W'(1))))
		else $error("entry count jumped");

	// only a put can add an entry
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == $past(cnt_q) + CNT_W'(1)) |-> $past(act_q == ACT_PUT))
		else $error("entry count grew without put");

	// no input taken while the key rows are being cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLR) |=> !$past(in_acc))
		else $error("word accepted during clearing pass");
`endif

endmodule

/* tb/integer_key_hash_table_top_tb.sv */
// self-checking testbench for the integer key hash table: directed and random words against a software table
module integer_key_hash_table_top_tb;
	import ihash_pkg::*;

	localparam int unsigned NBUCK         = DEF_NUM_BUCKETS;
	localparam int unsigned NWAYS         = DEF_WAYS;
	localparam int unsigned NSLOT         = NBUCK * NWAYS;
	localparam logic [ACT_W-1:0] ACT_NOP  = 2'd3;  // unused action code
	localparam int unsigned N_RANDOM      = 1600;
	localparam int unsigned HOT_BUCKETS   = 4;
	localparam int unsigned HOT_KEYS      = 7;     // more keys than ways, so buckets overflow
	localparam int unsigned SPREAD_KEYS   = 48;
	localparam int unsigned LONG_HOLD     = 400;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned MAX_PRINTS    = 40;
	localparam int unsigned CNT_LO        = VAL_W;
	localparam int unsigned PAD_LO        = VAL_W + ECNT_W;

	typedef struct {
		logic [ACT_W-1:0] act;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
		bit               hold_for_drain;  // wait until every result is back before sending
	} table_op_t;

	typedef struct {
		logic [STAT_W-1:0] status;
		logic [VAL_W-1:0]  rd;
		logic [ECNT_W-1:0] count;
	} table_res_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [ACT_W-1:0]      s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]     m_tuser;

	// software copy of the table
	bit               slot_used [NSLOT];
	logic [KEY_W-1:0] slot_key  [NSLOT];
	logic [VAL_W-1:0] slot_val  [NSLOT];
	int unsigned      live_entries = 0;

	table_op_t  pending_ops[$];
	table_res_t owed_results[$];
	table_op_t  offered;

	int unsigned send_gap = 0;
	int unsigned recv_stall = 0;
	int unsigned hold_left = 0;
	int unsigned rx_count = 0;
	int unsigned err_cnt = 0;
	logic [15:0] cycle_cnt = '0;
	logic        send_quiet;
	logic        recv_quiet;

	logic [KEY_W-1:0] hot_keys    [HOT_BUCKETS*HOT_KEYS];
	logic [KEY_W-1:0] spread_keys [SPREAD_KEYS];
	logic [KEY_W-1:0] crowd       [4];

	integer_key_hash_table_top #(
		.NUM_BUCKETS(NBUCK),
		.WAYS       (NWAYS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),   // lookup_key, entry_value
		.s_tuser (s_tuser),   // action
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),   // read_value, entry_count, zero pad
		.m_tuser (m_tuser)    // status
	);

	// integer mix of a key, modulo 2^32
	function automatic logic [KEY_W-1:0] wang32(input logic [KEY_W-1:0] k);
		logic [KEY_W-1:0] h;
		h = k;
		h = h + ~(h << 15);
		h = h ^ (h >> 10);
		h = h + (h << 3);
		h = h ^ (h >> 6);
		h = h + ~(h << 11);
		h = h ^ (h >> 16);
		return h;
	endfunction

	// bucket lookup and update, one result per word
	function automatic table_res_t apply_table_op(input table_op_t op);
		table_res_t  r;
		int unsigned base;
		int unsigned s;
		int unsigned hit_slot;
		int unsigned free_slot;
		int unsigned w;
		bit          hit;
		bit          has_free;
		base = (wang32(op.key) % NBUCK) * NWAYS;
		hit = 1'b0;
		has_free = 1'b0;
		hit_slot = 0;
		free_slot = 0;
		r.status = STAT_OK;
		r.rd = '0;
		for (w = 0; w < NWAYS; w++) begin
			s = base + w;
			if (slot_used[s]) begin
				if (!hit && slot_key[s] == op.key) begin
					hit = 1'b1;
					hit_slot = s;
				end
			end else if (!has_free) begin
				has_free = 1'b1;
				free_slot = s;
			end
		end
		case (op.act)
			ACT_PUT: begin
				if (hit) begin
					slot_val[hit_slot] = op.val;
				end else if (has_free) begin
					slot_used[free_slot] = 1'b1;
					slot_key[free_slot] = op.key;
					slot_val[free_slot] = op.val;
					live_entries++;
				end else begin
					r.status = STAT_FULL;
				end
			end
			ACT_GET: begin
				if (hit) r.rd = slot_val[hit_slot];
				else r.status = STAT_MISSING;
			end
			ACT_REMOVE: begin
				if (hit) begin
					slot_used[hit_slot] = 1'b0;
					if (live_entries != 0) live_entries--;
				end else begin
					r.status = STAT_MISSING;
				end
			end
			default: ;
		endcase
		r.count = ECNT_W'(live_entries);
		return r;
	endfunction

	function automatic int unsigned pick_gap(input bit quiet);
		int unsigned roll;
		if (quiet) return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60) return 0;
		if (roll < 95) return $urandom_range(1, 3);
		return $urandom_range(12, 50);
	endfunction

	function automatic logic [VAL_W-1:0] pick_value();
		int unsigned roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) return '0;
		if (roll == 1) return '1;
		return $urandom;
	endfunction

	function automatic logic [ACT_W-1:0] pick_action();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 40) return ACT_PUT;
		if (roll < 75) return ACT_GET;
		return ACT_REMOVE;
	endfunction

	function automatic logic [KEY_W-1:0] key_for_bucket(input int unsigned b);
		logic [KEY_W-1:0] k;
		k = $urandom;
		while (wang32(k) % NBUCK != b) k = $urandom;
		return k;
	endfunction

	function automatic void push_op(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] val);
		table_op_t op;
		op.act = act;
		op.key = key;
		op.val = val;
		op.hold_for_drain = 1'b0;
		pending_ops.push_back(op);
	endfunction

	task automatic note_mismatch(input string what, input logic [VAL_W-1:0] got,
			input logic [VAL_W-1:0] want);
		if (err_cnt < MAX_PRINTS)
			$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
		err_cnt++;
	endtask

	initial begin
		forever #4 clk = ~clk;
	end

	// free-running count: its bits mark stretches where one side never idles
	always @(posedge clk) cycle_cnt <= cycle_cnt + 1'b1;
	assign send_quiet = cycle_cnt[8];
	assign recv_quiet = cycle_cnt[9] & cycle_cnt[7];

	initial begin
		#8000000;
		$display("[integer_key_hash_table_top] ERROR");
		$finish;
	end

	// sender: offers words from pending_ops, predicts each one when it is taken
	always @(posedge clk or negedge arst_n) begin : drive_words
		int unsigned g;
		bit          slot_free;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			send_gap <= 0;
		end else begin
			slot_free = !s_tvalid || s_tready;
			g = 0;
			if (s_tvalid && s_tready) begin
				owed_results.push_back(apply_table_op(offered));
				g = pick_gap(send_quiet);
			end
			if (g != 0) begin
				s_tvalid <= 1'b0;
				send_gap <= g - 1;
			end else if (slot_free) begin
				if (send_gap != 0) begin
					s_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_ops.size() != 0 &&
						!(pending_ops[0].hold_for_drain && owed_results.size() != 0)) begin
					offered <= pending_ops[0];
					s_tvalid <= 1'b1;
					s_tdata <= {pending_ops[0].val, pending_ops[0].key};
					s_tuser <= pending_ops[0].act;
					void'(pending_ops.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stalls, plus two long hold-offs that back the block up
	always @(posedge clk or negedge arst_n) begin : drive_ready
		int unsigned g;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall <= 0;
			hold_left <= 0;
			rx_count <= 0;
		end else begin
			if (m_tvalid && m_tready) rx_count <= rx_count + 1;
			if (hold_left != 0) begin
				m_tready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (m_tvalid && m_tready && (rx_count == 299 || rx_count == 999)) begin
				m_tready <= 1'b0;
				hold_left <= LONG_HOLD;
			end else if (recv_stall != 0) begin
				m_tready <= 1'b0;
				recv_stall <= recv_stall - 1;
			end else begin
				g = pick_gap(recv_quiet);
				if (g != 0) begin
					m_tready <= 1'b0;
					recv_stall <= g - 1;
				end else begin
					m_tready <= 1'b1;
				end
			end
		end
	end

	// result checker: every word against the oldest owed result
	always @(posedge clk) begin : check_words
		table_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (owed_results.size() == 0) begin
				note_mismatch("word with nothing owed, read_value", m_tdata[VAL_W-1:0], '0);
			end else begin
				want = owed_results.pop_front();
				if (m_tuser !== want.status)
					note_mismatch("status", VAL_W'(m_tuser), VAL_W'(want.status));
				if (m_tdata[VAL_W-1:0] !== want.rd)
					note_mismatch("read_value", m_tdata[VAL_W-1:0], want.rd);
				if (m_tdata[CNT_LO +: ECNT_W] !== want.count)
					note_mismatch("entry_count", VAL_W'(m_tdata[CNT_LO +: ECNT_W]),
						VAL_W'(want.count));
				if (m_tdata[OUT_DATA_W-1:PAD_LO] !== '0)
					note_mismatch("pad bits", VAL_W'(m_tdata[OUT_DATA_W-1:PAD_LO]), '0);
			end
		end
	end

	initial begin : run_table
		int unsigned home;
		int unsigned directed_n;
		int unsigned roll;
		int unsigned b;
		int unsigned j;
		logic [KEY_W-1:0] k;

		// keys that share the bucket of key zero
		home = wang32('0) % NBUCK;
		for (j = 0; j < 4; j++) crowd[j] = key_for_bucket(home);
		for (j = 0; j < HOT_BUCKETS * HOT_KEYS; j++) begin
			if (j % HOT_KEYS == 0) b = $urandom_range(0, NBUCK - 1);
			hot_keys[j] = key_for_bucket(b);
		end
		for (j = 0; j < SPREAD_KEYS; j++) spread_keys[j] = $urandom;

		// directed: empty table, extreme keys and values, update, overflow, no-op code
		push_op(ACT_GET,    '0, '1);
		push_op(ACT_REMOVE, '0, '1);
		push_op(ACT_PUT,    '0, '0);
		push_op(ACT_PUT,    '1, '1);
		push_op(ACT_GET,    '0, '0);
		push_op(ACT_GET,    '1, '0);
		push_op(ACT_PUT,    '0, 32'hA5A5_5A5A);   // present key: value replaced
		push_op(ACT_GET,    '0, '1);
		push_op(ACT_PUT,    crowd[0], pick_value());
		push_op(ACT_PUT,    crowd[1], pick_value());
		push_op(ACT_PUT,    crowd[2], pick_value());
		push_op(ACT_PUT,    crowd[3], pick_value()); // bucket already full
		push_op(ACT_GET,    crowd[3], pick_value());
		push_op(ACT_NOP,    '0, '1);
		push_op(ACT_NOP,    $urandom, $urandom);
		push_op(ACT_REMOVE, crowd[0], '0);
		push_op(ACT_PUT,    crowd[3], 32'h1234_5678); // takes the freed way
		push_op(ACT_GET,    crowd[3], '0);
		push_op(ACT_PUT,    crowd[0], '1);
		push_op(ACT_REMOVE, '0, '0);
		push_op(ACT_REMOVE, '0, '0);
		push_op(ACT_GET,    '0, '0);
		push_op(ACT_REMOVE, '1, '0);
		push_op(ACT_GET,    crowd[1], '0);
		directed_n = pending_ops.size();

		// random: mostly traffic on a small key set so that hits, overflows and
		// removals keep happening, with some fresh keys and no-op codes as noise
		while (pending_ops.size() < directed_n + N_RANDOM) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				// overfill one hot bucket, read it all back, then drop about half
				b = $urandom_range(0, HOT_BUCKETS - 1) * HOT_KEYS;
				for (j = 0; j < HOT_KEYS; j++) push_op(ACT_PUT, hot_keys[b + j], pick_value());
				for (j = 0; j < HOT_KEYS; j++) push_op(ACT_GET, hot_keys[b + j], pick_value());
				for (j = 0; j < HOT_KEYS; j++)
					if ($urandom_range(0, 1) == 1) push_op(ACT_REMOVE, hot_keys[b + j], $urandom);
			end else if (roll < 50) begin
				k = hot_keys[$urandom_range(0, HOT_BUCKETS * HOT_KEYS - 1)];
				push_op(pick_action(), k, pick_value());
			end else if (roll < 80) begin
				k = spread_keys[$urandom_range(0, SPREAD_KEYS - 1)];
				push_op(pick_action(), k, pick_value());
			end else if (roll < 98) begin
				push_op(pick_action(), $urandom, pick_value());
			end else begin
				push_op(ACT_NOP, $urandom, $urandom);
			end
		end
		// sender pauses for a full drain at these points
		pending_ops[directed_n].hold_for_drain = 1'b1;
		pending_ops[directed_n + N_RANDOM / 2].hold_for_drain = 1'b1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || s_tvalid) @(posedge clk);
		while (owed_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_cnt == 0) $display("[integer_key_hash_table_top] OK");
		else $display("[integer_key_hash_table_top] ERROR");
		$finish;
	end

endmodule
